/* rtl/ring_exclusion_process_step_top_assert.svh */
// Assertion macros for the checker file of this block.
// Each macro expands to one labeled concurrent assertion on the rising clock edge.
`ifndef RING_EXCLUSION_PROCESS_STEP_TOP_ASSERT_SVH
`define RING_EXCLUSION_PROCESS_STEP_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define REP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define REP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/rep_pkg.sv */
`default_nettype none

package rep_pkg;

   // Fixed field widths of the item and register formats.
   localparam int MODE_W     = 2;
   localparam int PART_W     = 10;
   localparam int POS_W      = 12;
   localparam int PROB_W     = 16;
   localparam int RING_LEN_W = 13;
   localparam int NET_W      = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Packed channel widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 48;

   // Parameter defaults.
   localparam int DEF_MAX_SITES     = 4096;
   localparam int DEF_MAX_PARTICLES = 1024;
   localparam int DEF_PROB_BITS     = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_RING_LEN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRACER_PROB  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OTHER_PROB   = 2'd2;

   // Register reset values.
   localparam logic [RING_LEN_W-1:0] RST_RING_LEN = 13'd4096;
   localparam logic [PROB_W-1:0]     RST_PROB     = 16'd32768;

   // Shortest ring the block works on.
   localparam int MIN_RING = 2;

   // Saturation limits of the tracer displacement.
   localparam logic [NET_W-1:0] NET_MAX = 32'h7FFF_FFFF;
   localparam logic [NET_W-1:0] NET_MIN = 32'h8000_0000;

   // Width of the shared arithmetic unit; covers every site, length and count.
   localparam int ALU_W = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR = 2'd0,
      MODE_PLACE = 2'd1,
      MODE_STEP  = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_RANGE,
      ST_PLACE,
      ST_PROB,
      ST_INC,
      ST_WRAP,
      ST_OCC_RD,
      ST_OCC_MOVE,
      ST_OCC_MARK,
      ST_RESP
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type       op;
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_req_type;

   typedef struct packed {
      logic             lt;
      logic [ALU_W-1:0] res;
   } alu_rsp_type;

endpackage

`default_nettype wire

/* rtl/rep_alu.sv */
`default_nettype none

// Shared add/subtract unit. For a subtraction, lt flags a < b as unsigned values.
module rep_alu (
   input  rep_pkg::alu_req_type req,
   output rep_pkg::alu_rsp_type rsp
);

   logic [rep_pkg::ALU_W:0] wide;

   always_comb begin
      case (req.op)
         rep_pkg::ALU_ADD: begin
            wide = {1'b0, req.a} + {1'b0, req.b};
         end
         rep_pkg::ALU_SUB: begin
            wide = {1'b0, req.a} - {1'b0, req.b};
         end
         default: begin
            wide = '0;
         end
      endcase
      rsp.res = wide[rep_pkg::ALU_W-1:0];
      rsp.lt  = (req.op == rep_pkg::ALU_SUB) && wide[rep_pkg::ALU_W];
   end

endmodule

`default_nettype wire

/* rtl/ring_exclusion_process_step_top.sv */
// Channel   Direction  Handshake                 Contents
// req_      in         req_tvalid / req_tready   tuser: mode; tdata: particle, site, rand_u
// rsp_      out        rsp_tvalid / rsp_tready   tdata: position, moved, tracer_displacement
// csr_      in         csr_valid / csr_ready     csr_index, csr_data (register write)
//
// A result enters the output register once the sequencer has run the states for its item's
// mode; an out-of-range particle index goes straight to ST_RESP. The next item can be taken
// as soon as the result is registered. One shared add/subtract unit, registered memory reads
// and the one-site-per-cycle clearing sweep set these states. Reset is synchronous and active
// high, then the occupancy memory is swept with req_tready low. A stalled result holds in
// the output register; the next item still runs and waits behind it.
`default_nettype none

module ring_exclusion_process_step_top #(
   parameter int MAX_SITES     = rep_pkg::DEF_MAX_SITES,
   parameter int MAX_PARTICLES = rep_pkg::DEF_MAX_PARTICLES,
   parameter int PROB_BITS     = rep_pkg::DEF_PROB_BITS
) (
   input  wire                               clock,
   input  wire                               reset,
   // Input items.
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // Fields from bit 0 up: particle[9:0], site[21:10], rand_u[37:22], zero fill.
   input  wire  [rep_pkg::REQ_DATA_W-1:0]    req_tdata,
   // Fields from bit 0 up: mode[1:0].
   input  wire  [rep_pkg::MODE_W-1:0]        req_tuser,
   // Result items.
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // Fields from bit 0 up: position[11:0], moved[12], tracer_displacement[44:13], zero fill.
   output logic [rep_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Register writes.
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [rep_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [rep_pkg::CSR_DATA_W-1:0]    csr_data
);

   // Site address width, stored site width, effective length width.
   localparam int SITE_AW = $clog2(MAX_SITES);
   localparam int PW      = (SITE_AW > rep_pkg::POS_W) ? SITE_AW : rep_pkg::POS_W;
   localparam int LCW     = $clog2(MAX_SITES + 1);
   localparam int LW      = (LCW > rep_pkg::RING_LEN_W) ? LCW : rep_pkg::RING_LEN_W;
   // Particle table address width and the particle index widened to cover it.
   localparam int PA      = $clog2(MAX_PARTICLES);
   localparam int PXW     = (PA > rep_pkg::PART_W) ? PA : rep_pkg::PART_W;
   // Probability bits that take part in the compare.
   localparam int PBW     = (PROB_BITS < rep_pkg::PROB_W) ? PROB_BITS : rep_pkg::PROB_W;
   localparam int ZFILL   = rep_pkg::RSP_DATA_W - rep_pkg::NET_W - 1 - rep_pkg::POS_W;

   // Sequencer and item registers.
   rep_pkg::state_type               state_ff, state_in;
   logic [SITE_AW-1:0]               cnt_ff, cnt_in;
   rep_pkg::mode_type                mode_ff, mode_in;
   logic [rep_pkg::PART_W-1:0]       part_ff, part_in;
   logic [rep_pkg::POS_W-1:0]        site_ff, site_in;
   logic [rep_pkg::PROB_W-1:0]       rand_ff, rand_in;
   logic                             right_ff, right_in;
   logic                             inrange_ff, inrange_in;
   logic [PW-1:0]                    pos_ff, pos_in;
   logic [PW:0]                      t_ff, t_in;
   logic [PW-1:0]                    next_ff, next_in;
   logic                             moved_ff, moved_in;
   logic [rep_pkg::NET_W-1:0]        net_ff, net_in;

   // Configuration registers.
   logic [rep_pkg::RING_LEN_W-1:0]   ring_len_ff, ring_len_in;
   logic [rep_pkg::PROB_W-1:0]       tprob_ff, tprob_in;
   logic [rep_pkg::PROB_W-1:0]       oprob_ff, oprob_in;

   // Output register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [rep_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   // Particle site table: undefined until written, read data registered.
   logic [PW-1:0]                    ps_mem [MAX_PARTICLES];
   logic [PW-1:0]                    ps_q_ff;
   logic [PA-1:0]                    ps_addr;
   logic                             ps_we;
   logic [PW-1:0]                    ps_wdata;

   // Occupancy memory: one bit per site, one write and one read port.
   logic                             occ_mem [MAX_SITES];
   logic                             occ_q_ff;
   logic                             occ_we;
   logic [SITE_AW-1:0]               occ_waddr;
   logic                             occ_wdata;
   logic [SITE_AW-1:0]               occ_raddr;

   // Shared arithmetic unit.
   rep_pkg::alu_req_type             alu_req;
   rep_pkg::alu_rsp_type             alu_rsp;

   // Derived values.
   logic [LW-1:0]                    ring_raw;
   logic [LW-1:0]                    len_eff;
   logic [PXW-1:0]                   part_x;
   logic [PXW-1:0]                   req_part_x;
   logic                             req_part_ok;
   logic [PW-1:0]                    site_x;
   logic [PBW-1:0]                   prob_sel;
   logic                             req_fire;
   rep_pkg::mode_type                req_mode;

   rep_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   // The ring length acts as clamped into the range the lattice supports.
   assign ring_raw = LW'(ring_len_ff);
   always_comb begin
      if (ring_raw < LW'(rep_pkg::MIN_RING)) begin
         len_eff = LW'(rep_pkg::MIN_RING);
      end else if (ring_raw > LW'(MAX_SITES)) begin
         len_eff = LW'(MAX_SITES);
      end else begin
         len_eff = ring_raw;
      end
   end

   assign req_fire    = req_tvalid && req_tready;
   assign req_mode    = rep_pkg::mode_type'(req_tuser);
   assign req_part_x  = PXW'(req_tdata[rep_pkg::PART_W-1:0]);
   assign req_part_ok = {1'b0, req_part_x} < (PXW + 1)'(MAX_PARTICLES);
   assign part_x      = PXW'(part_ff);
   assign site_x      = PW'(site_ff);
   assign prob_sel    = (part_ff == '0) ? tprob_ff[PBW-1:0] : oprob_ff[PBW-1:0];

   assign ps_addr     = part_x[PA-1:0];
   assign occ_raddr   = next_ff[SITE_AW-1:0];

   assign req_tready  = (state_ff == rep_pkg::ST_IDLE);
   assign csr_ready   = 1'b1;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   // Register writes; an index past the list is ignored.
   always_comb begin
      ring_len_in = ring_len_ff;
      tprob_in    = tprob_ff;
      oprob_in    = oprob_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rep_pkg::CSR_RING_LEN: begin
               ring_len_in = csr_data[rep_pkg::RING_LEN_W-1:0];
            end
            rep_pkg::CSR_TRACER_PROB: begin
               tprob_in = csr_data;
            end
            rep_pkg::CSR_OTHER_PROB: begin
               oprob_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer: next state, datapath control and memory strobes.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mode_in      = mode_ff;
      part_in      = part_ff;
      site_in      = site_ff;
      rand_in      = rand_ff;
      right_in     = right_ff;
      inrange_in   = inrange_ff;
      pos_in       = pos_ff;
      t_in         = t_ff;
      next_in      = next_ff;
      moved_in     = moved_ff;
      net_in       = net_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      ps_we        = 1'b0;
      ps_wdata     = site_x;
      occ_we       = 1'b0;
      occ_waddr    = cnt_ff;
      occ_wdata    = 1'b0;

      alu_req.op   = rep_pkg::ALU_ADD;
      alu_req.a    = '0;
      alu_req.b    = '0;

      case (state_ff)
         rep_pkg::ST_INIT, rep_pkg::ST_CLEAR: begin
            // Clearing sweep, one site per cycle.
            occ_we    = 1'b1;
            occ_waddr = cnt_ff;
            occ_wdata = 1'b0;
            if (cnt_ff == SITE_AW'(MAX_SITES - 1)) begin
               if (state_ff == rep_pkg::ST_CLEAR) begin
                  net_in   = '0;
                  state_in = rep_pkg::ST_RESP;
               end else begin
                  state_in = rep_pkg::ST_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + SITE_AW'(1);
            end
         end
         rep_pkg::ST_IDLE: begin
            if (req_fire) begin
               mode_in  = req_mode;
               part_in  = req_tdata[rep_pkg::PART_W-1:0];
               site_in  = req_tdata[rep_pkg::PART_W +: rep_pkg::POS_W];
               rand_in  = req_tdata[rep_pkg::PART_W + rep_pkg::POS_W +: rep_pkg::PROB_W];
               pos_in   = '0;
               moved_in = 1'b0;
               cnt_in   = '0;
               if (req_mode == rep_pkg::MODE_CLEAR) begin
                  state_in = rep_pkg::ST_CLEAR;
               end else if (!req_part_ok) begin
                  state_in = rep_pkg::ST_RESP;
               end else if (req_mode == rep_pkg::MODE_STEP) begin
                  state_in = rep_pkg::ST_PROB;
               end else begin
                  state_in = rep_pkg::ST_RANGE;
               end
            end
         end
         rep_pkg::ST_RANGE: begin
            // Place target must lie inside the ring; the table read is under way.
            alu_req.op = rep_pkg::ALU_SUB;
            alu_req.a  = rep_pkg::ALU_W'(site_x);
            alu_req.b  = rep_pkg::ALU_W'(len_eff);
            inrange_in = alu_rsp.lt;
            state_in   = rep_pkg::ST_PLACE;
         end
         rep_pkg::ST_PLACE: begin
            if (mode_ff == rep_pkg::MODE_PLACE && inrange_ff) begin
               ps_we     = 1'b1;
               ps_wdata  = site_x;
               occ_we    = 1'b1;
               occ_waddr = site_x[SITE_AW-1:0];
               occ_wdata = 1'b1;
               pos_in    = site_x;
            end else begin
               pos_in = ps_q_ff;
            end
            state_in = rep_pkg::ST_RESP;
         end
         rep_pkg::ST_PROB: begin
            // The jump goes right when the random fraction is below the probability.
            alu_req.op = rep_pkg::ALU_SUB;
            alu_req.a  = rep_pkg::ALU_W'(rand_ff[PBW-1:0]);
            alu_req.b  = rep_pkg::ALU_W'(prob_sel);
            right_in   = alu_rsp.lt;
            state_in   = rep_pkg::ST_INC;
         end
         rep_pkg::ST_INC: begin
            pos_in     = ps_q_ff;
            alu_req.op = right_ff ? rep_pkg::ALU_ADD : rep_pkg::ALU_SUB;
            alu_req.a  = rep_pkg::ALU_W'(ps_q_ff);
            alu_req.b  = rep_pkg::ALU_W'(1);
            t_in       = alu_rsp.res[PW:0];
            state_in   = rep_pkg::ST_WRAP;
         end
         rep_pkg::ST_WRAP: begin
            // Wrap at the ring ends: past the last site goes to site zero, and below
            // site zero goes to the last site.
            alu_req.op = rep_pkg::ALU_SUB;
            if (right_ff) begin
               alu_req.a = rep_pkg::ALU_W'(t_ff);
               alu_req.b = rep_pkg::ALU_W'(len_eff);
               next_in   = alu_rsp.lt ? t_ff[PW-1:0] : '0;
            end else begin
               alu_req.a = rep_pkg::ALU_W'(len_eff);
               alu_req.b = rep_pkg::ALU_W'(1);
               next_in   = (pos_ff == '0) ? alu_rsp.res[PW-1:0] : t_ff[PW-1:0];
            end
            state_in = rep_pkg::ST_OCC_RD;
         end
         rep_pkg::ST_OCC_RD: begin
            state_in = rep_pkg::ST_OCC_MOVE;
         end
         rep_pkg::ST_OCC_MOVE: begin
            // The old site takes the target's old bit, as the exclusion rule leaves it.
            occ_we    = 1'b1;
            occ_waddr = pos_ff[SITE_AW-1:0];
            occ_wdata = occ_q_ff;
            moved_in  = !occ_q_ff;
            if (!occ_q_ff) begin
               ps_we    = 1'b1;
               ps_wdata = next_ff;
               pos_in   = next_ff;
            end
            state_in = rep_pkg::ST_OCC_MARK;
         end
         rep_pkg::ST_OCC_MARK: begin
            occ_we    = 1'b1;
            occ_waddr = next_ff[SITE_AW-1:0];
            occ_wdata = 1'b1;
            alu_req.op = right_ff ? rep_pkg::ALU_ADD : rep_pkg::ALU_SUB;
            alu_req.a  = net_ff;
            alu_req.b  = rep_pkg::ALU_W'(1);
            // Tracer displacement counts with saturation at both limits.
            if (moved_ff && part_ff == '0) begin
               if ((right_ff && net_ff != rep_pkg::NET_MAX) ||
                   (!right_ff && net_ff != rep_pkg::NET_MIN)) begin
                  net_in = alu_rsp.res;
               end
            end
            state_in = rep_pkg::ST_RESP;
         end
         rep_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {ZFILL'(0), net_ff, moved_ff, pos_ff[rep_pkg::POS_W-1:0]};
               state_in     = rep_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rep_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rep_pkg::ST_INIT;
         cnt_ff       <= '0;
         net_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ring_len_ff  <= rep_pkg::RST_RING_LEN;
         tprob_ff     <= rep_pkg::RST_PROB;
         oprob_ff     <= rep_pkg::RST_PROB;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         net_ff       <= net_in;
         rsp_valid_ff <= rsp_valid_in;
         ring_len_ff  <= ring_len_in;
         tprob_ff     <= tprob_in;
         oprob_ff     <= oprob_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      part_ff     <= part_in;
      site_ff     <= site_in;
      rand_ff     <= rand_in;
      right_ff    <= right_in;
      inrange_ff  <= inrange_in;
      pos_ff      <= pos_in;
      t_ff        <= t_in;
      next_ff     <= next_in;
      moved_ff    <= moved_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (ps_we) begin
         ps_mem[ps_addr] <= ps_wdata;
      end
      ps_q_ff <= ps_mem[ps_addr];
   end

   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[occ_waddr] <= occ_wdata;
      end
      occ_q_ff <= occ_mem[occ_raddr];
   end

endmodule

`default_nettype wire

/* rtl/rep_checker.sv */
`default_nettype none
`include "ring_exclusion_process_step_top_assert.svh"

// Port-level checks of the step engine.
module rep_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            req_tvalid,
   input wire                            req_tready,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [rep_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // A stalled result holds its value.
   `REP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // The clearing sweep after reset keeps the input closed.
   `REP_ASSERT_SAME(a_init_busy, clock, reset, $past(reset), !req_tready, "item taken during the reset sweep")

   // An accepted item keeps the block busy in the next cycle.
   `REP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "second item taken back to back")

   // A new result is loaded only while the sequencer is away from idle.
   `REP_ASSERT_SAME(a_rsp_from_work, clock, reset, $rose(rsp_tvalid), $past(!req_tready), "result appeared from idle")

endmodule

bind ring_exclusion_process_step_top rep_checker u_rep_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
